@@ hw/rtl/whbc_pkg.sv @@
package whbc_pkg;

  localparam int CoordW     = 7;
  localparam int CfgW       = 12;
  localparam int DimW       = 7;
  localparam int CfgIdxW    = 3;
  localparam int MaxGridDim = 64;
  localparam int CornerW    = 14;
  localparam int CornerMin  = -(1 << (CornerW - 1));
  localparam int CornerMax  = (1 << (CornerW - 1)) - 1;

  // Q8 cell size: |right - left| * 256 fits 20 bits plus sign
  localparam int CellW      = CfgW + 9;
  localparam int ResetCell  = (4095 * 256) / 16;
  localparam int ResetDim   = 16;
  localparam int ResetEdge  = 4095;

  localparam int PosW       = 30;
  localparam int SqW        = 56;
  localparam int RootW      = SqW / 2;
  localparam int UnitFrac   = 14;
  localparam int UnitOne    = 1 << UnitFrac;
  localparam int UnitW      = UnitFrac + 2;
  localparam int QuoW       = UnitFrac + 1;
  localparam int NumW       = PosW + UnitFrac;
  localparam int FifoDepth  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegGridLeft,
    RegGridTop,
    RegGridRight,
    RegGridBottom,
    RegGridRows,
    RegGridCols
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgW-1:0]         left;
    logic [CfgW-1:0]         top;
    logic signed [CellW-1:0] cw;
    logic signed [CellW-1:0] ch;
    logic                    busy;
  } geo_t;

  typedef struct packed {
    logic signed [PosW-1:0]  x1;
    logic signed [PosW-1:0]  y1;
    logic signed [PosW-1:0]  dx;
    logic signed [PosW-1:0]  dy;
    logic signed [CellW-1:0] ext;
    logic signed [CellW-1:0] th;
    logic                    nf;
    logic                    last;
  } item_t;

endpackage

@@ hw/rtl/whbc_if.sv @@
interface whbc_in_if import whbc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] start_col;
  logic signed [CoordW-1:0] start_row;
  logic signed [CoordW-1:0] end_col;
  logic signed [CoordW-1:0] end_row;
  logic                     last_word;

  modport source(output valid, start_col, start_row, end_col, end_row, last_word,
                 input ready);
  modport sink(input valid, start_col, start_row, end_col, end_row, last_word,
               output ready);
endinterface

interface whbc_out_if import whbc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [CornerW-1:0] corner_a_x;
  logic signed [CornerW-1:0] corner_a_y;
  logic signed [CornerW-1:0] corner_b_x;
  logic signed [CornerW-1:0] corner_b_y;
  logic signed [CornerW-1:0] corner_c_x;
  logic signed [CornerW-1:0] corner_c_y;
  logic signed [CornerW-1:0] corner_d_x;
  logic signed [CornerW-1:0] corner_d_y;
  logic                      last_out;

  modport source(output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                 corner_c_x, corner_c_y, corner_d_x, corner_d_y, last_out,
                 input ready);
  modport sink(input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
               corner_c_x, corner_c_y, corner_d_x, corner_d_y, last_out,
               output ready);
endinterface

@@ hw/rtl/word_highlight_box_corners_unit.sv @@
// channel   dir  handshake       words
// in_i      in   valid / ready   start/end col,row, last_word
// out_o     out  valid / ready   corners a..d x,y, last_out
// cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// One word per cycle while input is not held by a config write or a stalled output;
// output valid follows the input accept through the queue, squares, sum, a 28-stage
// square root, operand prep, a 15-stage unit-vector divider, products, corners.
// A config write stalls input while the cell-size divider runs.
// Reset is asynchronous and active low; no clearing pass.
// A stalled output freezes the back pipeline; the two-entry queue takes two more words,
// then input ready drops.
module word_highlight_box_corners_unit import whbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  whbc_in_if.sink            in_i,
  whbc_out_if.source         out_o
);

  geo_t  geo;
  item_t f_item, q_item;
  logic  push, q_full, q_valid, back_ready;

  whbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geo_o      (geo)
  );

  whbc_front u_front (
    .geo_i  (geo),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push),
    .item_o (f_item)
  );

  whbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (f_item),
    .full_o  (q_full),
    .pop_i   (back_ready),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  whbc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (q_item),
    .ready_o (back_ready),
    .out_o   (out_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !geo.busy)
    else $error("word accepted while cell size is recomputed");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_i.ready)
    else $error("input open right after a config write");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !back_ready) |=> q_valid)
    else $error("queued word lost while back end stalled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue written while full");

endmodule

@@ hw/rtl/whbc_cfg.sv @@
module whbc_cfg import whbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output geo_t               geo_o
);

  localparam int DivW = CfgW + 8;
  localparam int CntW = $clog2(DivW + 1);

  typedef enum logic [1:0] {Idle, Load, Run, Done} state_e;

  state_e                  state_q;
  logic [CfgW-1:0]         left_q, top_q, right_q, bottom_q;
  logic [DimW-1:0]         rows_q, cols_q;
  logic signed [CellW-1:0] cw_q, ch_q;
  logic [CntW-1:0]         cnt_q;
  logic [DivW-1:0]         quo_c_q, quo_r_q;
  logic [DimW-1:0]         rem_c_q, rem_r_q, div_c_q, div_r_q;
  logic                    neg_c_q, neg_r_q;

  logic signed [CfgW:0]    diff_c, diff_r;
  logic [DimW:0]           nxt_c, nxt_r;
  logic                    ge_c, ge_r;
  logic [DimW-1:0]         dim_c, dim_r;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) r = DimW'(1);
    else if (d > DimW'(MaxGridDim)) r = DimW'(MaxGridDim);
    return r;
  endfunction

  always_comb begin
    diff_c = $signed({1'b0, right_q}) - $signed({1'b0, left_q});
    diff_r = $signed({1'b0, bottom_q}) - $signed({1'b0, top_q});
    dim_c  = clamp_dim(cols_q);
    dim_r  = clamp_dim(rows_q);
    nxt_c  = {rem_c_q, quo_c_q[DivW-1]};
    nxt_r  = {rem_r_q, quo_r_q[DivW-1]};
    ge_c   = nxt_c >= {1'b0, div_c_q};
    ge_r   = nxt_r >= {1'b0, div_r_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= Idle;
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= CfgW'(ResetEdge);
      bottom_q <= CfgW'(ResetEdge);
      rows_q   <= DimW'(ResetDim);
      cols_q   <= DimW'(ResetDim);
      cw_q     <= CellW'(ResetCell);
      ch_q     <= CellW'(ResetCell);
      cnt_q    <= '0;
      quo_c_q  <= '0;
      quo_r_q  <= '0;
      rem_c_q  <= '0;
      rem_r_q  <= '0;
      div_c_q  <= '0;
      div_r_q  <= '0;
      neg_c_q  <= 1'b0;
      neg_r_q  <= 1'b0;
    end else if (cfg_we_i) begin
      state_q <= Load;
      case (cfg_reg_e'(cfg_idx_i))
        RegGridLeft:   left_q   <= cfg_data_i;
        RegGridTop:    top_q    <= cfg_data_i;
        RegGridRight:  right_q  <= cfg_data_i;
        RegGridBottom: bottom_q <= cfg_data_i;
        RegGridRows:   rows_q   <= cfg_data_i[DimW-1:0];
        RegGridCols:   cols_q   <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end else begin
      case (state_q)
        Load: begin
          neg_c_q <= diff_c[CfgW];
          neg_r_q <= diff_r[CfgW];
          quo_c_q <= {(diff_c[CfgW] ? CfgW'(-diff_c) : CfgW'(diff_c)), 8'b0};
          quo_r_q <= {(diff_r[CfgW] ? CfgW'(-diff_r) : CfgW'(diff_r)), 8'b0};
          rem_c_q <= '0;
          rem_r_q <= '0;
          div_c_q <= dim_c;
          div_r_q <= dim_r;
          cnt_q   <= CntW'(DivW);
          state_q <= Run;
        end
        Run: begin
          rem_c_q <= ge_c ? DimW'(nxt_c - {1'b0, div_c_q}) : DimW'(nxt_c);
          rem_r_q <= ge_r ? DimW'(nxt_r - {1'b0, div_r_q}) : DimW'(nxt_r);
          quo_c_q <= {quo_c_q[DivW-2:0], ge_c};
          quo_r_q <= {quo_r_q[DivW-2:0], ge_r};
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) state_q <= Done;
        end
        Done: begin
          cw_q    <= neg_c_q ? -CellW'(quo_c_q) : CellW'(quo_c_q);
          ch_q    <= neg_r_q ? -CellW'(quo_r_q) : CellW'(quo_r_q);
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign geo_o.left = left_q;
  assign geo_o.top  = top_q;
  assign geo_o.cw   = cw_q;
  assign geo_o.ch   = ch_q;
  assign geo_o.busy = (state_q != Idle) || cfg_we_i;

endmodule

@@ hw/rtl/whbc_front.sv @@
module whbc_front import whbc_pkg::*; (
  input  geo_t        geo_i,
  whbc_in_if.sink     in_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic signed [CoordW:0]  diff_c, diff_r;
  logic signed [PosW-1:0]  px, py;
  logic signed [CellW:0]   half_w, half_h, quarter;
  logic signed [CellW-1:0] cw_h, ch_h, sel;

  assign in_i.ready = !full_i && !geo_i.busy;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    diff_c = in_i.end_col - in_i.start_col;
    diff_r = in_i.end_row - in_i.start_row;
    px     = in_i.start_col * geo_i.cw;
    py     = in_i.start_row * geo_i.ch;

    half_w = geo_i.cw;
    if (geo_i.cw < 0) half_w = geo_i.cw + 1;
    half_h = geo_i.ch;
    if (geo_i.ch < 0) half_h = geo_i.ch + 1;
    quarter = geo_i.cw + geo_i.ch;
    if (quarter < 0) quarter = quarter + 3;
    cw_h = CellW'(half_w >>> 1);
    ch_h = CellW'(half_h >>> 1);

    item_o.dx  = diff_c * geo_i.cw;
    item_o.dy  = diff_r * geo_i.ch;
    item_o.x1  = PosW'($signed({1'b0, geo_i.left, 8'b0})) + px + PosW'(cw_h);
    item_o.y1  = PosW'($signed({1'b0, geo_i.top, 8'b0})) + py + PosW'(ch_h);
    item_o.ext = cw_h;

    // orientation: near-zero dx is vertical, near-zero dy horizontal
    if (item_o.dx >= -2 && item_o.dx <= 2) sel = cw_h;
    else if (item_o.dy >= -2 && item_o.dy <= 2) sel = ch_h;
    else sel = CellW'(quarter >>> 2);
    item_o.th = sel - CellW'(512);

    item_o.nf = (in_i.start_col == -1) || (in_i.start_row == -1) ||
                (in_i.end_col == -1) || (in_i.end_row == -1);
    item_o.last = in_i.last_word;
  end

endmodule

@@ hw/rtl/whbc_fifo.sv @@
module whbc_fifo import whbc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t rdata_o
);

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  item_t           mem [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(FifoDepth);
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem[rd_q];

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (do_pop) rd_q <= inc(rd_q);
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hw/rtl/whbc_back.sv @@
module whbc_back import whbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        ready_o,
  whbc_out_if.source  out_o
);

  localparam int MulW = UnitW + CellW;
  localparam int QW   = PosW + 2;

  typedef struct packed {
    logic [NumW-1:0]  rx;
    logic [NumW-1:0]  ry;
    logic [QuoW-1:0]  qx;
    logic [QuoW-1:0]  qy;
    logic [RootW-1:0] len;
    logic             nx;
    logic             ny;
  } div_t;

  logic en;

  // squares
  logic                     v0_q;
  item_t                    it0_q;
  logic [SqW-1:0]           sqx0_q, sqy0_q;
  logic signed [2*PosW-1:0] sqx_full, sqy_full;

  // square root, index 0 holds the sum
  logic [RootW:0]  srt_v_q;
  item_t           srt_it_q  [RootW+1];
  logic [SqW-1:0]  srt_rem_q [RootW+1];
  logic [SqW-1:0]  srt_res_q [RootW+1];
  logic [SqW-1:0]  srt_rem_d [RootW];
  logic [SqW-1:0]  srt_res_d [RootW];

  // unit vector divide, index 0 holds the prepared operands
  logic [QuoW:0]   dv_v_q;
  item_t           dv_it_q [QuoW+1];
  div_t            dv_q    [QuoW+1];
  div_t            dv_d    [QuoW];
  div_t            prep;
  logic [PosW-1:0] magx, magy;

  // products
  logic                    vm_q;
  item_t                   itm_q;
  logic signed [MulW-1:0]  pex_q, pey_q, pox_q, poy_q;
  logic signed [UnitW-1:0] ux, uy;
  logic                    len0;

  // corners
  logic signed [QW-1:0]    x1, y1, x2, y2, ex, ey, ox, oy;
  logic                    ov_q;
  logic [CornerW-1:0]      ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
  logic                    last_q;

  function automatic logic signed [MulW-1:0] tz_unit(input logic signed [MulW-1:0] p);
    logic signed [MulW-1:0] a;
    a = p;
    if (p < 0) a = p + MulW'(UnitOne - 1);
    return a >>> UnitFrac;
  endfunction

  function automatic logic [CornerW-1:0] to_corner(input logic signed [QW-1:0] q);
    logic signed [QW-1:0] v;
    v = q - QW'(128);
    if (v < 0) v = v + QW'(255);
    v = v >>> 8;
    if (v < CornerMin) v = QW'(CornerMin);
    if (v > CornerMax) v = QW'(CornerMax);
    return v[CornerW-1:0];
  endfunction

  assign en      = !ov_q || out_o.ready;
  assign ready_o = en;

  assign sqx_full = item_i.dx * item_i.dx;
  assign sqy_full = item_i.dy * item_i.dy;

  always_comb begin
    for (int j = 0; j < RootW; j++) begin
      logic [SqW-1:0] b, trial;
      b     = SqW'(1) << (2 * (RootW - 1 - j));
      trial = srt_res_q[j] + b;
      if (srt_rem_q[j] >= trial) begin
        srt_rem_d[j] = srt_rem_q[j] - trial;
        srt_res_d[j] = (srt_res_q[j] >> 1) + b;
      end else begin
        srt_rem_d[j] = srt_rem_q[j];
        srt_res_d[j] = srt_res_q[j] >> 1;
      end
    end
  end

  always_comb begin
    magx      = srt_it_q[RootW].dx[PosW-1] ? PosW'(-srt_it_q[RootW].dx)
                                           : PosW'(srt_it_q[RootW].dx);
    magy      = srt_it_q[RootW].dy[PosW-1] ? PosW'(-srt_it_q[RootW].dy)
                                           : PosW'(srt_it_q[RootW].dy);
    prep.rx   = NumW'(magx) << UnitFrac;
    prep.ry   = NumW'(magy) << UnitFrac;
    prep.qx   = '0;
    prep.qy   = '0;
    prep.len  = srt_res_q[RootW][RootW-1:0];
    prep.nx   = srt_it_q[RootW].dx[PosW-1];
    prep.ny   = srt_it_q[RootW].dy[PosW-1];
  end

  always_comb begin
    for (int j = 0; j < QuoW; j++) begin
      logic [NumW-1:0] trial;
      logic            gx, gy;
      trial    = NumW'(dv_q[j].len) << (QuoW - 1 - j);
      gx       = dv_q[j].rx >= trial;
      gy       = dv_q[j].ry >= trial;
      dv_d[j]    = dv_q[j];
      dv_d[j].rx = gx ? dv_q[j].rx - trial : dv_q[j].rx;
      dv_d[j].ry = gy ? dv_q[j].ry - trial : dv_q[j].ry;
      dv_d[j].qx = {dv_q[j].qx[QuoW-2:0], gx};
      dv_d[j].qy = {dv_q[j].qy[QuoW-2:0], gy};
    end
  end

  always_comb begin
    len0 = dv_q[QuoW].len == '0;
    if (len0) begin
      // degenerate word: horizontal direction
      ux = UnitW'(UnitOne);
      uy = '0;
    end else begin
      ux = dv_q[QuoW].nx ? -$signed({1'b0, dv_q[QuoW].qx}) : $signed({1'b0, dv_q[QuoW].qx});
      uy = dv_q[QuoW].ny ? -$signed({1'b0, dv_q[QuoW].qy}) : $signed({1'b0, dv_q[QuoW].qy});
    end
  end

  always_comb begin
    x1 = QW'(itm_q.x1);
    y1 = QW'(itm_q.y1);
    x2 = QW'(itm_q.x1) + QW'(itm_q.dx);
    y2 = QW'(itm_q.y1) + QW'(itm_q.dy);
    ex = QW'(tz_unit(pex_q));
    ey = QW'(tz_unit(pey_q));
    ox = -QW'(tz_unit(pox_q));
    oy = QW'(tz_unit(poy_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      srt_v_q <= '0;
      dv_v_q  <= '0;
      vm_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else if (en) begin
      v0_q    <= valid_i;
      srt_v_q <= {srt_v_q[RootW-1:0], v0_q};
      dv_v_q  <= {dv_v_q[QuoW-1:0], srt_v_q[RootW]};
      vm_q    <= dv_v_q[QuoW];
      ov_q    <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q  <= item_i;
      sqx0_q <= SqW'(sqx_full);
      sqy0_q <= SqW'(sqy_full);

      srt_it_q[0]  <= it0_q;
      srt_rem_q[0] <= sqx0_q + sqy0_q;
      srt_res_q[0] <= '0;
      for (int j = 0; j < RootW; j++) begin
        srt_it_q[j+1]  <= srt_it_q[j];
        srt_rem_q[j+1] <= srt_rem_d[j];
        srt_res_q[j+1] <= srt_res_d[j];
      end

      dv_it_q[0] <= srt_it_q[RootW];
      dv_q[0]    <= prep;
      for (int j = 0; j < QuoW; j++) begin
        dv_it_q[j+1] <= dv_it_q[j];
        dv_q[j+1]    <= dv_d[j];
      end

      itm_q <= dv_it_q[QuoW];
      pex_q <= ux * dv_it_q[QuoW].ext;
      pey_q <= uy * dv_it_q[QuoW].ext;
      pox_q <= uy * dv_it_q[QuoW].th;
      poy_q <= ux * dv_it_q[QuoW].th;

      last_q <= itm_q.last;
      if (itm_q.nf) begin
        ax_q <= '1; ay_q <= '1; bx_q <= '1; by_q <= '1;
        cx_q <= '1; cy_q <= '1; dx_q <= '1; dy_q <= '1;
      end else begin
        ax_q <= to_corner(x1 - ex + ox);
        ay_q <= to_corner(y1 - ey + oy);
        bx_q <= to_corner(x2 + ex + ox);
        by_q <= to_corner(y2 + ey + oy);
        cx_q <= to_corner(x2 + ex - ox);
        cy_q <= to_corner(y2 + ey - oy);
        dx_q <= to_corner(x1 - ex - ox);
        dy_q <= to_corner(y1 - ey - oy);
      end
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.corner_a_x = $signed(ax_q);
  assign out_o.corner_a_y = $signed(ay_q);
  assign out_o.corner_b_x = $signed(bx_q);
  assign out_o.corner_b_y = $signed(by_q);
  assign out_o.corner_c_x = $signed(cx_q);
  assign out_o.corner_c_y = $signed(cy_q);
  assign out_o.corner_d_x = $signed(dx_q);
  assign out_o.corner_d_y = $signed(dy_q);
  assign out_o.last_out   = last_q;

endmodule

@@ sim/tb_word_highlight_box_corners_unit.sv @@
`timescale 1ns / 100ps

module tb_word_highlight_box_corners_unit;
  import whbc_pkg::*;

  localparam int DrainCycles   = 80;
  localparam int WatchdogLimit = 5000;

  typedef struct packed {
    logic signed [CornerW-1:0] ax;
    logic signed [CornerW-1:0] ay;
    logic signed [CornerW-1:0] bx;
    logic signed [CornerW-1:0] by;
    logic signed [CornerW-1:0] cx;
    logic signed [CornerW-1:0] cy;
    logic signed [CornerW-1:0] dx;
    logic signed [CornerW-1:0] dy;
    logic                      last;
  } box_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  whbc_in_if  in_if();
  whbc_out_if out_if();

  word_highlight_box_corners_unit DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // grid registers as the block should hold them
  logic [CfgW-1:0] grid_left_q, grid_top_q, grid_right_q, grid_bottom_q;
  logic [DimW-1:0] grid_rows_q, grid_cols_q;

  box_t expected_boxes[$];
  int   error_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic signed [CornerW-1:0] to_pixel(longint q8);
    longint v;
    v = (q8 - 128) / 256;
    if (v < CornerMin) v = CornerMin;
    if (v > CornerMax) v = CornerMax;
    return v[CornerW-1:0];
  endfunction

  function automatic longint clamp_dim(logic [DimW-1:0] d);
    if (d < 1) return 1;
    if (d > MaxGridDim) return MaxGridDim;
    return longint'(d);
  endfunction

  function automatic box_t frame_corners(logic signed [CoordW-1:0] sc, logic signed [CoordW-1:0] sr,
                                         logic signed [CoordW-1:0] ec, logic signed [CoordW-1:0] er,
                                         logic last);
    longint cw, ch, x1, y1, x2, y2, ddx, ddy, len, ux, uy, ext, ex, ey, th, ox, oy;
    longint unsigned sq, res, bitv;
    box_t b;
    b.last = last;
    if (sc == -1 || sr == -1 || ec == -1 || er == -1) begin
      {b.ax, b.ay, b.bx, b.by, b.cx, b.cy, b.dx, b.dy} = '1;
      return b;
    end
    cw = ((longint'(grid_right_q) - longint'(grid_left_q)) * 256) / clamp_dim(grid_cols_q);
    ch = ((longint'(grid_bottom_q) - longint'(grid_top_q)) * 256) / clamp_dim(grid_rows_q);
    x1 = longint'(grid_left_q) * 256 + longint'(sc) * cw + cw / 2;
    y1 = longint'(grid_top_q) * 256 + longint'(sr) * ch + ch / 2;
    x2 = longint'(grid_left_q) * 256 + longint'(ec) * cw + cw / 2;
    y2 = longint'(grid_top_q) * 256 + longint'(er) * ch + ch / 2;
    ddx = x2 - x1;
    ddy = y2 - y1;
    sq = longint'(ddx * ddx) + longint'(ddy * ddy);
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > sq) bitv >>= 2;
    while (bitv != 0) begin
      if (sq >= res + bitv) begin
        sq -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    len = longint'(res);
    if (len == 0) begin
      ux = UnitOne;
      uy = 0;
    end else begin
      ux = (ddx * UnitOne) / len;
      uy = (ddy * UnitOne) / len;
    end
    ext = cw / 2;
    ex = (ux * ext) / UnitOne;
    ey = (uy * ext) / UnitOne;
    x1 -= ex;
    y1 -= ey;
    x2 += ex;
    y2 += ey;
    if ((ddx < 0 ? -ddx : ddx) * 100 < 256) th = cw / 2;
    else if ((ddy < 0 ? -ddy : ddy) * 100 < 256) th = ch / 2;
    else th = (cw + ch) / 4;
    th -= 512;
    ox = (-uy * th) / UnitOne;
    oy = (ux * th) / UnitOne;
    b.ax = to_pixel(x1 + ox);
    b.ay = to_pixel(y1 + oy);
    b.bx = to_pixel(x2 + ox);
    b.by = to_pixel(y2 + oy);
    b.cx = to_pixel(x2 - ox);
    b.cy = to_pixel(y2 - oy);
    b.dx = to_pixel(x1 - ox);
    b.dy = to_pixel(y1 - oy);
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver, result check and watchdog
  always @(posedge clk_i) begin
    box_t want;
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing accepted for %0d cycles", WatchdogLimit);
      $display("** word_highlight_box_corners_unit: FAILED **");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_boxes.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_boxes.pop_front();
        if (out_if.corner_a_x !== want.ax) report_mismatch("corner_a_x", out_if.corner_a_x, want.ax);
        if (out_if.corner_a_y !== want.ay) report_mismatch("corner_a_y", out_if.corner_a_y, want.ay);
        if (out_if.corner_b_x !== want.bx) report_mismatch("corner_b_x", out_if.corner_b_x, want.bx);
        if (out_if.corner_b_y !== want.by) report_mismatch("corner_b_y", out_if.corner_b_y, want.by);
        if (out_if.corner_c_x !== want.cx) report_mismatch("corner_c_x", out_if.corner_c_x, want.cx);
        if (out_if.corner_c_y !== want.cy) report_mismatch("corner_c_y", out_if.corner_c_y, want.cy);
        if (out_if.corner_d_x !== want.dx) report_mismatch("corner_d_x", out_if.corner_d_x, want.dx);
        if (out_if.corner_d_y !== want.dy) report_mismatch("corner_d_y", out_if.corner_d_y, want.dy);
        if (out_if.last_out !== want.last) report_mismatch("last_out", out_if.last_out, want.last);
      end
    end
  end

  task automatic send_word(int sc, int sr, int ec, int er, int last);
    logic signed [CoordW-1:0] c0, r0, c1, r1;
    logic                     lw;
    c0 = CoordW'(sc);
    r0 = CoordW'(sr);
    c1 = CoordW'(ec);
    r1 = CoordW'(er);
    lw = last[0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.start_col <= c0;
    in_if.start_row <= r0;
    in_if.end_col   <= c1;
    in_if.end_row   <= r1;
    in_if.last_word <= lw;
    expected_boxes.push_back(frame_corners(c0, r0, c1, r1, lw));
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, int data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegGridLeft:   grid_left_q   = CfgW'(data);
      RegGridTop:    grid_top_q    = CfgW'(data);
      RegGridRight:  grid_right_q  = CfgW'(data);
      RegGridBottom: grid_bottom_q = CfgW'(data);
      RegGridRows:   grid_rows_q   = DimW'(data);
      RegGridCols:   grid_cols_q   = DimW'(data);
      default: ;
    endcase
  endtask

  task automatic set_grid(int l, int t, int r, int b, int rows, int cols);
    wait_drained();
    cfg_write(RegGridLeft, l);
    cfg_write(RegGridTop, t);
    cfg_write(RegGridRight, r);
    cfg_write(RegGridBottom, b);
    cfg_write(RegGridRows, rows);
    cfg_write(RegGridCols, cols);
  endtask

  task automatic test_directed();
    send_word(-1, 3, 5, 3, 0);
    send_word(2, -1, 5, 3, 1);
    send_word(2, 3, -1, 3, 0);
    send_word(2, 3, 5, -1, 1);
    send_word(-1, -1, -1, -1, 1);
    send_word(4, 4, 4, 4, 0);
    send_word(0, 0, 0, 0, 1);
    send_word(0, 0, 15, 0, 0);
    send_word(15, 2, 0, 2, 0);
    send_word(3, 0, 3, 15, 0);
    send_word(3, 15, 3, 0, 1);
    send_word(0, 0, 15, 15, 0);
    send_word(15, 0, 0, 15, 0);
    send_word(2, 9, 6, 5, 1);
    send_word(63, 63, 63, 63, 0);
    send_word(0, 0, 63, 63, 0);
    send_word(63, 0, 0, 63, 1);
    send_word(-64, -64, 63, 63, 0);
    send_word(-2, 5, 20, -64, 1);
    send_word(1, 2, 40, 3, 0);
  endtask

  task automatic test_random(int count);
    int sc, sr, ec, er;
    int kind, nc, nr, dc, dr, span, c2, r2;
    repeat (count) begin
      kind = $urandom_range(99);
      nc = int'(clamp_dim(grid_cols_q));
      nr = int'(clamp_dim(grid_rows_q));
      if (kind < 75) begin
        sc = $urandom_range(nc - 1);
        sr = $urandom_range(nr - 1);
        dc = $urandom_range(2) - 1;
        dr = $urandom_range(2) - 1;
        span = $urandom_range((nc > nr ? nc : nr) - 1);
        c2 = sc + dc * span;
        r2 = sr + dr * span;
        ec = (c2 < 0 || c2 > 63) ? sc : c2;
        er = (r2 < 0 || r2 > 63) ? sr : r2;
      end else begin
        sc = $urandom_range(127);
        sr = $urandom_range(127);
        ec = $urandom_range(127);
        er = $urandom_range(127);
        if (kind < 88) begin
          case ($urandom_range(3))
            0: sc = -1;
            1: sr = -1;
            2: ec = -1;
            default: er = -1;
          endcase
        end
      end
      send_word(sc, sr, ec, er, $urandom_range(1));
    end
  endtask

  task automatic test_grid_settings(int per_setting);
    int l, t;
    set_grid(0, 0, 4095, 4095, 64, 64);
    test_random(per_setting);
    set_grid(4095, 4095, 0, 0, 1, 1);
    test_random(per_setting);
    l = $urandom_range(2000);
    t = $urandom_range(2000);
    set_grid(l, t, l + 1 + $urandom_range(2000), t + 1 + $urandom_range(2000),
             $urandom_range(1, 64), $urandom_range(1, 64));
    test_random(per_setting);
    set_grid(100, 50, 900, 700, 0, 127);
    test_random(per_setting);
    set_grid($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
             $urandom_range(4095), $urandom_range(127), $urandom_range(127));
    test_random(per_setting);
  endtask

  initial begin
    error_count   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 26;
    recv_idle_pct = 80;
    grid_left_q   = '0;
    grid_top_q    = '0;
    grid_right_q  = CfgW'(ResetEdge);
    grid_bottom_q = CfgW'(ResetEdge);
    grid_rows_q   = DimW'(ResetDim);
    grid_cols_q   = DimW'(ResetDim);
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegGridLeft;
    cfg_data_i    = '0;
    in_if.valid     = 1'b0;
    in_if.start_col = '0;
    in_if.start_row = '0;
    in_if.end_col   = '0;
    in_if.end_row   = '0;
    in_if.last_word = 1'b0;
    out_if.ready    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_grid(0, 0, 4095, 4095, 64, 64);
    test_directed();
    test_grid_settings(100);
    send_idle_pct = 80;
    recv_idle_pct = 26;
    test_grid_settings(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_grid_settings(110);

    wait_drained();
    if (error_count == 0) begin
      $display("** word_highlight_box_corners_unit: PASSED **");
    end else begin
      $display("** word_highlight_box_corners_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/whbc_pkg.sv
hw/rtl/whbc_if.sv
hw/rtl/whbc_cfg.sv
hw/rtl/whbc_front.sv
hw/rtl/whbc_fifo.sv
hw/rtl/whbc_back.sv
hw/rtl/word_highlight_box_corners_unit.sv
sim/tb_word_highlight_box_corners_unit.sv
